// ===== rtl/core/spq_pkg.sv =====
// Shared types and codes of the stable priority queue.
package spq_pkg;

    typedef enum logic [2:0] {
        STAT_INSERTED = 3'd0,
        STAT_REMOVED  = 3'd1,
        STAT_UNDERFLOW = 3'd2,
        STAT_OVERFLOW = 3'd3,
        STAT_REJECTED = 3'd4
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } command_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

endpackage

// ===== rtl/core/stable_priority_queue.sv =====
// Top level of the stable priority queue: level FIFOs held in one RAM.
//
// Usage. Requests arrive on the in_valid / in_ready channel. A request with
// command insert stores entry_value under entry_priority (valid 1 to
// PRIORITY_LEVELS); a request with command remove takes out the entry of
// the highest priority, the oldest one first among equal priorities.
// Every request gives exactly one result on out_valid / out_ready: status,
// removed_value, removed_priority (both zero unless an entry was removed)
// and occupancy, the number of entries held after the request.
//
// Latency and throughput. An insert, and any request that is rejected or
// reports overflow or underflow, is answered in the cycle after it is
// accepted; while the receiver takes each result, the next request may
// follow at once: one request per cycle. A successful remove reads the
// shared RAM, whose read is registered, so its result is loaded in the
// read state, and no new request is accepted until it is back in idle.
//
// Reset clears all level counters and pointers, so the queue starts empty;
// the RAM contents need no clearing. When the receiver stalls, the result
// is held in the output register and in_ready stays low until it is taken
// or is being taken in the same cycle.
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY        = 16,
    parameter int PRIORITY_LEVELS = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [31:0] entry_value,
    input  logic [2:0]  entry_priority,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] removed_value,
    output logic [2:0]  removed_priority,
    output logic [4:0]  occupancy
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int LVL_W = $clog2(PRIORITY_LEVELS);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int ADDR_W = LVL_W + PTR_W;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    // Each priority level is a circular FIFO in its own region of the RAM.
    // Oldest-first within a level and highest level first across levels is
    // exactly the service order of the queue.
    logic [PTR_W-1:0] head_reg [PRIORITY_LEVELS];
    logic [PTR_W-1:0] head_next [PRIORITY_LEVELS];
    logic [PTR_W-1:0] tail_reg [PRIORITY_LEVELS];
    logic [PTR_W-1:0] tail_next [PRIORITY_LEVELS];
    logic [CNT_W-1:0] lvl_cnt_reg [PRIORITY_LEVELS];
    logic [CNT_W-1:0] lvl_cnt_next [PRIORITY_LEVELS];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [LVL_W-1:0] best_lvl_reg, best_lvl_next;
    state_t           state_reg, state_next;

    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    logic [31:0]      rvalue_reg, rvalue_next;
    logic [2:0]       rprio_reg, rprio_next;
    logic [4:0]       occ_reg, occ_next;

    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [31:0]       ram_rdata;

    logic             accept;
    logic             prio_bad;
    logic [LVL_W-1:0] ins_lvl;
    logic [LVL_W-1:0] best_lvl;

    spq_ram #(
        .WIDTH (32),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (entry_value),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    // Priorities outside 1 .. PRIORITY_LEVELS are refused before the full check.
    assign prio_bad = (entry_priority == 3'd0) || (int'(entry_priority) > PRIORITY_LEVELS);
    assign ins_lvl  = LVL_W'(entry_priority - 3'd1);

    // Highest non-empty level; the later match overrides the earlier one.
    always_comb
    begin
        best_lvl = '0;
        for (int i = 0; i < PRIORITY_LEVELS; i++)
        begin
            if (lvl_cnt_reg[i] != '0)
            begin
                best_lvl = LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        lvl_cnt_next   = lvl_cnt_reg;
        count_next     = count_reg;
        best_lvl_next  = best_lvl_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        rvalue_next    = rvalue_reg;
        rprio_next     = rprio_reg;
        occ_next       = occ_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = {ins_lvl, tail_reg[ins_lvl]};
        ram_raddr      = {best_lvl, head_reg[best_lvl]};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rvalue_next = '0;
                    rprio_next  = '0;
                    if (command == CMD_INSERT)
                    begin
                        out_valid_next = 1'b1;
                        occ_next       = 5'(count_reg);
                        if (prio_bad)
                        begin
                            status_next = STAT_REJECTED;
                        end
                        else if (int'(count_reg) == CAPACITY)
                        begin
                            status_next = STAT_OVERFLOW;
                        end
                        else
                        begin
                            ram_we               = 1'b1;
                            tail_next[ins_lvl]   = (tail_reg[ins_lvl] == PTR_W'(CAPACITY - 1))
                                                 ? '0 : tail_reg[ins_lvl] + 1'b1;
                            lvl_cnt_next[ins_lvl] = lvl_cnt_reg[ins_lvl] + 1'b1;
                            count_next           = count_reg + 1'b1;
                            status_next          = STAT_INSERTED;
                            occ_next             = 5'(count_reg + 1'b1);
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = STAT_UNDERFLOW;
                            occ_next       = '0;
                        end
                        else
                        begin
                            ram_re                 = 1'b1;
                            head_next[best_lvl]    = (head_reg[best_lvl] == PTR_W'(CAPACITY - 1))
                                                   ? '0 : head_reg[best_lvl] + 1'b1;
                            lvl_cnt_next[best_lvl] = lvl_cnt_reg[best_lvl] - 1'b1;
                            count_next             = count_reg - 1'b1;
                            best_lvl_next          = best_lvl;
                            state_next             = ST_READ;
                        end
                    end
                end
            end
            ST_READ:
            begin
                // The output register is empty here: acceptance required it.
                out_valid_next = 1'b1;
                status_next    = STAT_REMOVED;
                rvalue_next    = ram_rdata;
                rprio_next     = 3'(best_lvl_reg) + 3'd1;
                occ_next       = 5'(count_reg);
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PRIORITY_LEVELS; i++)
            begin
                head_reg[i]    <= '0;
                tail_reg[i]    <= '0;
                lvl_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            lvl_cnt_reg   <= lvl_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_lvl_reg <= best_lvl_next;
        status_reg   <= status_next;
        rvalue_reg   <= rvalue_next;
        rprio_reg    <= rprio_next;
        occ_reg      <= occ_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign removed_value    = rvalue_reg;
    assign removed_priority = rprio_reg;
    assign occupancy        = occ_reg;

endmodule

// ===== rtl/core/spq_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
module spq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/spq_checker.sv =====
// Port-level checker of the stable priority queue and its bind.
module spq_checker
    import spq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        command,
    input logic [31:0] entry_value,
    input logic [2:0]  entry_priority,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [31:0] removed_value,
    input logic [2:0]  removed_priority,
    input logic [4:0]  occupancy
);

    // A stalled result stays valid with its status and occupancy held.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occupancy))
        else $error("stalled result changed");

    // Only a removal carries a value and a priority.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STAT_REMOVED) |-> removed_value == '0 && removed_priority == '0)
        else $error("non-removal result carries data");

    // A removed entry always has a nonzero priority.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_REMOVED) |-> removed_priority != '0)
        else $error("removed entry with priority zero");

    // Underflow only on an empty queue; an insert leaves it non-empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_UNDERFLOW) |-> occupancy == '0)
        else $error("underflow with entries held");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_INSERTED) |-> occupancy != '0)
        else $error("insert left queue empty");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
